// File: design/rvx_pkg.sv
package rvx_pkg;

   localparam int REG_COUNT_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
   localparam logic [6:0]  F7_BASE    = 7'h00;
   localparam logic [6:0]  F7_ALT     = 7'h20;
   localparam logic [6:0]  F7_MULDIV  = 7'h01;
   localparam logic [4:0]  REG_A0     = 5'd10;

   localparam logic [2:0] F3_MUL    = 3'd0;
   localparam logic [2:0] F3_MULH   = 3'd1;
   localparam logic [2:0] F3_MULHU  = 3'd3;
   localparam logic [2:0] F3_DIV    = 3'd4;
   localparam logic [2:0] F3_DIVU   = 3'd5;
   localparam logic [2:0] F3_REM    = 3'd6;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [1:0] STAT_NORMAL  = 2'd0;
   localparam logic [1:0] STAT_TRAP    = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;

   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_SHALF = 2'd1;
   localparam logic [1:0] KIND_UHALF = 2'd2;
   localparam logic [1:0] KIND_UBYTE = 2'd3;

   typedef enum logic [2:0] {
      CLS_SIMPLE, CLS_MUL, CLS_DIV, CLS_TRAP, CLS_INVALID, CLS_LOADRET
   } cls_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DIVF
   } st_type;

   typedef struct packed {
      logic        action;
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_request;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] mem_wdata;
      logic [1:0]  status;
      logic [31:0] trap_value;
   } rsp_type;

   typedef struct packed {
      cls_type     cls;
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [31:0] load_data;
   } item_type;

endpackage

// File: design/rvx_ram.sv
module rvx_ram import rvx_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = REG_COUNT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

// File: design/rvx_front.sv
module rvx_front import rvx_pkg::*; (
   input  logic     req_valid,
   input  req_type  req_data,
   input  logic     full,
   output logic     push,
   output item_type item
);

   logic [6:0] op;
   logic [2:0] f3;
   logic [6:0] f7;
   cls_type    cls;

   assign op = req_data.instruction[6:0];
   assign f3 = req_data.instruction[14:12];
   assign f7 = req_data.instruction[31:25];

   // classify so the back end knows which work is legal
   always_comb begin
      cls = CLS_INVALID;
      if (req_data.action) begin
         cls = CLS_LOADRET;
      end else begin
         unique case (op)
            OP_LUI, OP_AUIPC, OP_JAL: cls = CLS_SIMPLE;
            OP_JALR:   if (f3 == 3'd0) cls = CLS_SIMPLE;
            OP_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) cls = CLS_SIMPLE;
            OP_LOAD: begin
               case (f3) inside
                  3'd1, 3'd2, 3'd4, 3'd5: cls = CLS_SIMPLE;
                  default: cls = CLS_INVALID;
               endcase
            end
            OP_STORE: if (f3 <= 3'd2) cls = CLS_SIMPLE;
            OP_IMM: begin
               case (f3) inside
                  3'd0, 3'd3, 3'd4, 3'd7: cls = CLS_SIMPLE;
                  3'd1: if (f7 == F7_BASE) cls = CLS_SIMPLE;
                  3'd5: if (f7 == F7_BASE || f7 == F7_ALT) cls = CLS_SIMPLE;
                  default: cls = CLS_INVALID;
               endcase
            end
            OP_REG: begin
               if (f7 == F7_BASE) begin
                  cls = CLS_SIMPLE;
               end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
                  cls = CLS_SIMPLE;
               end else if (f7 == F7_MULDIV) begin
                  case (f3) inside
                     F3_MUL, F3_MULH, F3_MULHU: cls = CLS_MUL;
                     F3_DIV, F3_DIVU, F3_REM:   cls = CLS_DIV;
                     default: cls = CLS_INVALID;
                  endcase
               end
            end
            OP_SYSTEM: if (req_data.instruction == EBREAK_WORD) cls = CLS_TRAP;
            default: cls = CLS_INVALID;
         endcase
      end
   end

   assign push             = req_valid && !full;
   assign item.cls         = cls;
   assign item.instruction = req_data.instruction;
   assign item.pc          = req_data.pc;
   assign item.load_data   = req_data.load_data;

endmodule

// File: design/rvx_queue.sv
module rvx_queue import rvx_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output item_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_C  = PW'(QUEUE_DEPTH - 1);

   item_type      ent_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;

   assign full       = (cnt_ff == DEPTH_C);
   assign head_valid = (cnt_ff != '0);
   assign head       = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (wp_ff == LAST_C) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (rp_ff == LAST_C) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_item;
      end
   end

endmodule

// File: design/rvx_back.sv
module rvx_back import rvx_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  item_type head,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  logic     rsp_stall
);

   localparam int AW = $clog2(REG_COUNT);
   localparam logic [5:0] RC = 6'(REG_COUNT);

   st_type   state_ff, state_in;
   item_type cur_ff, cur_in;
   logic     ok1_ff, ok1_in, ok2_ff, ok2_in;
   logic [REG_COUNT-1:0] vld_ff;
   logic [4:0] pdest_ff, pdest_in;
   logic [1:0] pkind_ff, pkind_in;
   logic     out_valid_ff;
   rsp_type  out_ff;

   logic [4:0]  ra1, ra2;
   logic [31:0] rdata1, rdata2, a, b;
   logic        wr_en, ram_we;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;
   logic        fin;
   rsp_type     fin_rsp;

   logic signed [65:0] prod_ff, prod_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in, dvs_ff, dvs_in, sp_ff, sp_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        negq_ff, negq_in, negr_ff, negr_in, wrem_ff, wrem_in, bz_ff, bz_in;

   logic [32:0] sh_w, diff_w;

   // execute-stage decode
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4;
   rsp_type     ex_rsp;
   logic        ex_wr;
   logic [31:0] ex_res;
   logic        ex_load;
   logic [1:0]  ex_kind;
   logic        tk;
   logic        sgn;
   logic [31:0] ld_ext;

   rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (wr_idx[AW-1:0]),
      .wdata   (wr_val),
      .raddr_a (ra1[AW-1:0]),
      .raddr_b (ra2[AW-1:0]),
      .rdata_a (rdata1),
      .rdata_b (rdata2)
   );

   assign ra1    = (head.cls == CLS_TRAP) ? REG_A0 : head.instruction[19:15];
   assign ra2    = head.instruction[24:20];
   assign ok1_in = ({1'b0, ra1} < RC) && vld_ff[ra1[AW-1:0]];
   assign ok2_in = ({1'b0, ra2} < RC) && vld_ff[ra2[AW-1:0]];
   assign ram_we = wr_en && (wr_idx != 5'd0) && ({1'b0, wr_idx} < RC);

   assign a = ok1_ff ? rdata1 : 32'd0;
   assign b = ok2_ff ? rdata2 : 32'd0;

   assign op    = cur_ff.instruction[6:0];
   assign rd    = cur_ff.instruction[11:7];
   assign f3    = cur_ff.instruction[14:12];
   assign f7    = cur_ff.instruction[31:25];
   assign imm_i = {{20{cur_ff.instruction[31]}}, cur_ff.instruction[31:20]};
   assign imm_s = {{20{cur_ff.instruction[31]}}, cur_ff.instruction[31:25],
                   cur_ff.instruction[11:7]};
   assign imm_b = {{19{cur_ff.instruction[31]}}, cur_ff.instruction[31],
                   cur_ff.instruction[7], cur_ff.instruction[30:25],
                   cur_ff.instruction[11:8], 1'b0};
   assign imm_j = {{11{cur_ff.instruction[31]}}, cur_ff.instruction[31],
                   cur_ff.instruction[19:12], cur_ff.instruction[20],
                   cur_ff.instruction[30:21], 1'b0};
   assign pc4   = cur_ff.pc + 32'd4;
   assign sgn   = (f3 != F3_DIVU);

   always_comb begin
      unique case (pkind_ff)
         KIND_WORD:  ld_ext = cur_ff.load_data;
         KIND_SHALF: ld_ext = {{16{cur_ff.load_data[15]}}, cur_ff.load_data[15:0]};
         KIND_UHALF: ld_ext = {16'd0, cur_ff.load_data[15:0]};
         default:    ld_ext = {24'd0, cur_ff.load_data[7:0]};
      endcase
   end

   // simple instructions, traps and invalid patterns
   always_comb begin
      ex_rsp         = '0;
      ex_rsp.next_pc = pc4;
      ex_wr          = 1'b0;
      ex_res         = 32'd0;
      ex_load        = 1'b0;
      ex_kind        = KIND_WORD;
      tk             = 1'b0;
      if (cur_ff.cls == CLS_TRAP) begin
         ex_rsp.status     = STAT_TRAP;
         ex_rsp.trap_value = a;
      end else if (cur_ff.cls == CLS_INVALID) begin
         ex_rsp.status = STAT_INVALID;
      end else begin
         unique case (op)
            OP_LUI: begin
               ex_wr  = 1'b1;
               ex_res = {cur_ff.instruction[31:12], 12'd0};
            end
            OP_AUIPC: begin
               ex_wr  = 1'b1;
               ex_res = cur_ff.pc + {cur_ff.instruction[31:12], 12'd0};
            end
            OP_JAL: begin
               ex_wr          = 1'b1;
               ex_res         = pc4;
               ex_rsp.next_pc = cur_ff.pc + imm_j;
            end
            OP_JALR: begin
               ex_wr          = 1'b1;
               ex_res         = pc4;
               ex_rsp.next_pc = (a + imm_i) & ~32'd1;
            end
            OP_BRANCH: begin
               unique case (f3)
                  3'd0:    tk = (a == b);
                  3'd1:    tk = (a != b);
                  3'd4:    tk = ($signed(a) < $signed(b));
                  3'd5:    tk = !($signed(a) < $signed(b));
                  3'd6:    tk = (a < b);
                  default: tk = (a >= b);
               endcase
               if (tk) begin
                  ex_rsp.next_pc = cur_ff.pc + imm_b;
               end
            end
            OP_LOAD: begin
               ex_load            = 1'b1;
               ex_rsp.mem_request = MEM_READ;
               ex_rsp.mem_addr    = a + imm_i;
               unique case (f3)
                  3'd2: begin ex_kind = KIND_WORD;  ex_rsp.mem_size = SIZE_WORD; end
                  3'd1: begin ex_kind = KIND_SHALF; ex_rsp.mem_size = SIZE_HALF; end
                  3'd5: begin ex_kind = KIND_UHALF; ex_rsp.mem_size = SIZE_HALF; end
                  default: begin ex_kind = KIND_UBYTE; ex_rsp.mem_size = SIZE_BYTE; end
               endcase
            end
            OP_STORE: begin
               ex_rsp.mem_request = MEM_WRITE;
               ex_rsp.mem_addr    = a + imm_s;
               ex_rsp.mem_size    = f3[1:0];
               unique case (f3[1:0])
                  SIZE_BYTE: ex_rsp.mem_wdata = {24'd0, b[7:0]};
                  SIZE_HALF: ex_rsp.mem_wdata = {16'd0, b[15:0]};
                  default:   ex_rsp.mem_wdata = b;
               endcase
            end
            OP_IMM: begin
               ex_wr = 1'b1;
               unique case (f3)
                  3'd0:    ex_res = a + imm_i;
                  3'd3:    ex_res = {31'd0, a < imm_i};
                  3'd4:    ex_res = a ^ imm_i;
                  3'd1:    ex_res = a << imm_i[4:0];
                  3'd5:    ex_res = f7[5] ? 32'($signed(a) >>> imm_i[4:0])
                                          : a >> imm_i[4:0];
                  default: ex_res = a & imm_i;
               endcase
            end
            default: begin
               ex_wr = 1'b1;
               unique case (f3)
                  3'd0:    ex_res = f7[5] ? a - b : a + b;
                  3'd1:    ex_res = a << b[4:0];
                  3'd2:    ex_res = {31'd0, $signed(a) < $signed(b)};
                  3'd3:    ex_res = {31'd0, a < b};
                  3'd4:    ex_res = a ^ b;
                  3'd5:    ex_res = f7[5] ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                  3'd6:    ex_res = a | b;
                  default: ex_res = a & b;
               endcase
            end
         endcase
      end
   end

   assign sh_w   = {rem_ff[31:0], quo_ff[31]};
   assign diff_w = sh_w - {1'b0, dvs_ff};

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      pop            = 1'b0;
      fin            = 1'b0;
      fin_rsp        = '0;
      fin_rsp.next_pc = pc4;
      wr_en          = 1'b0;
      wr_idx         = rd;
      wr_val         = 32'd0;
      pdest_in       = pdest_ff;
      pkind_in       = pkind_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      dvs_in         = dvs_ff;
      sp_in          = sp_ff;
      cnt_in         = cnt_ff;
      negq_in        = negq_ff;
      negr_in        = negr_ff;
      wrem_in        = wrem_ff;
      bz_in          = bz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && !out_valid_ff) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.cls == CLS_LOADRET) begin
               fin      = 1'b1;
               fin_rsp  = '0;
               wr_en    = 1'b1;
               wr_idx   = pdest_ff;
               wr_val   = ld_ext;
               pdest_in = 5'd0;
               state_in = ST_IDLE;
            end else if (cur_ff.cls == CLS_MUL) begin
               prod_in  = $signed({(f3 != F3_MULHU) && a[31], a})
                        * $signed({(f3 != F3_MULHU) && b[31], b});
               state_in = ST_MUL;
            end else if (cur_ff.cls == CLS_DIV) begin
               negq_in  = sgn && (a[31] ^ b[31]);
               negr_in  = sgn && a[31];
               wrem_in  = (f3 == F3_REM);
               bz_in    = (b == 32'd0);
               sp_in    = (f3 == F3_REM) ? a : 32'hffff_ffff;
               quo_in   = (sgn && a[31]) ? 32'd0 - a : a;
               dvs_in   = (sgn && b[31]) ? 32'd0 - b : b;
               rem_in   = 33'd0;
               cnt_in   = 5'd0;
               state_in = ST_DIV;
            end else begin
               fin     = 1'b1;
               fin_rsp = ex_rsp;
               wr_en   = ex_wr;
               wr_val  = ex_res;
               if (ex_load) begin
                  pdest_in = rd;
                  pkind_in = ex_kind;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            fin      = 1'b1;
            wr_en    = 1'b1;
            wr_val   = (f3 == F3_MUL) ? prod_ff[31:0] : prod_ff[63:32];
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            // one restoring step per cycle
            rem_in = diff_w[32] ? sh_w : diff_w;
            quo_in = {quo_ff[30:0], !diff_w[32]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_DIVF;
            end
         end
         default: begin
            fin   = 1'b1;
            wr_en = 1'b1;
            if (bz_ff) begin
               wr_val = sp_ff;
            end else if (wrem_ff) begin
               wr_val = negr_ff ? 32'd0 - rem_ff[31:0] : rem_ff[31:0];
            end else begin
               wr_val = negq_ff ? 32'd0 - quo_ff : quo_ff;
            end
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         pdest_ff     <= 5'd0;
         pkind_ff     <= KIND_WORD;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pdest_ff <= pdest_in;
         pkind_ff <= pkind_in;
         if (ram_we) begin
            vld_ff[wr_idx[AW-1:0]] <= 1'b1;
         end
         if (fin) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      sp_ff   <= sp_in;
      cnt_ff  <= cnt_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      wrem_ff <= wrem_in;
      bz_ff   <= bz_in;
      if (pop) begin
         ok1_ff <= ok1_in;
         ok2_ff <= ok2_in;
      end
      if (fin) begin
         out_ff <= fin_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: design/rv32im_subset_execute.sv
// RV32IM subset execute block with its own register file.
// Input channel req_*: one transaction is an instruction to execute
// (action 0, with instruction word and pc) or the read data for the
// outstanding load (action 1, load_data). Result channel rsp_*: exactly
// one transaction per input, in order, giving next pc, memory request,
// status and trap value.
// A two-entry queue separates the decode front from the execute back, so
// inputs keep arriving while a result waits on a stalled receiver.
// Simple work and load returns finish in the execute state; multiplies
// register one 33x33 product before the write-back; divide and remainder
// use a radix-2 restoring divider, one bit per cycle, then a final fix-up.
// The back end takes one transaction at a time and starts the next only
// once it is through with the last and the output register is free.
// Reset clears the queue, the register valid bits (all registers read
// zero), the pending load destination and the output valid flag.
// While rsp_stall is high the result is held; once the queue fills,
// req_stall goes high.
module rv32im_subset_execute import rvx_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     full, push, pop, head_valid;
   item_type push_item, head;

   // classify each incoming transaction
   rvx_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .full      (full),
      .push      (push),
      .item      (push_item)
   );

   assign req_stall = full;

   // hold classified work between front and back
   rvx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   // execute, write back and drive the result register
   rvx_back #(.REG_COUNT(REG_COUNT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule
